@@ rtl/vtpd_pkg.sv @@
// Shared types and constants for the vertex transform with perspective divide.
package vtpd_pkg;

  localparam int COORD_W = 32;
  localparam int PROD_W  = 64;
  localparam int SUM_W   = 66;
  localparam int NUM_REGS = 8;
  localparam int QUO_W   = 32;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      w_is_zero;
    logic                      clipped;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] c0;
    logic signed [COORD_W-1:0] c1;
    logic signed [COORD_W-1:0] c2;
    logic signed [COORD_W-1:0] c3;
  } row_t;

endpackage

@@ rtl/vertex_transform_perspective_divide.sv @@
// Vertex transform by a configured 4x4 matrix with perspective divide.
//
// A point request on point/point_valid/point_ready is multiplied by the
// matrix (w taken as one), and x, y and z are divided by the resulting w.
// The result leaves on result/result_valid/result_ready.
// The matrix is written over the APB port: register i at byte 8*i, 64 bits,
// and the user must write it only while the pipeline is empty; the block itself does not enforce this.
// Stages: one multiply stage, one sum stage, one divider setup stage,
// 32 divider stages (one quotient bit each) and one saturation stage.
// Throughput is one point per cycle while the output is not stalled.
// A zero w gives zero coordinates with w_is_zero set; a quotient outside
// 32 bits saturates and sets clipped.
// When the receiver holds result_ready low while result_valid is high, the whole pipeline holds and
// point_ready drops in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and loads the identity matrix.
module vertex_transform_perspective_divide
  import vtpd_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  point_t      point,
  input  logic        point_valid,
  output logic        point_ready,
  output result_t     result,
  output logic        result_valid,
  input  logic        result_ready
);

  localparam int LAT   = 36;
  localparam int WZ_D  = LAT - 2;
  localparam logic [63:0] ONE = 64'(1) << FRACTION_BITS;

  logic [63:0] regs [NUM_REGS];
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[5:3];
  assign prdata = regs[ridx];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= ONE;
      regs[1] <= '0;
      regs[2] <= ONE << 32;
      regs[3] <= '0;
      regs[4] <= '0;
      regs[5] <= ONE;
      regs[6] <= '0;
      regs[7] <= ONE << 32;
    end else if (psel && penable && pwrite) begin
      regs[ridx] <= pwdata;
    end
  end

  logic en;
  logic vld [LAT];

  assign en           = !vld[LAT-1] || result_ready;
  assign point_ready  = en;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= point_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  logic signed [SUM_W-1:0] sums [4];
  logic signed [QUO_W-1:0] quos [3];
  logic                    clips [3];

  for (genvar r = 0; r < 4; r++) begin : g_row
    row_t rw;
    assign rw.c0 = regs[2*r][31:0];
    assign rw.c1 = regs[2*r][63:32];
    assign rw.c2 = regs[2*r+1][31:0];
    assign rw.c3 = regs[2*r+1][63:32];
    vtpd_dot #(.FRACTION_BITS(FRACTION_BITS)) u_dot (
      .clk (clk),
      .en  (en),
      .row (rw),
      .pt  (point),
      .sum (sums[r])
    );
  end

  for (genvar r = 0; r < 3; r++) begin : g_div
    vtpd_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clk  (clk),
      .en   (en),
      .num  (sums[r]),
      .den  (sums[3]),
      .quo  (quos[r]),
      .clip (clips[r])
    );
  end

  logic wzd [WZ_D];

  always_ff @(posedge clk) begin
    if (en) begin
      wzd[0] <= sums[3] == '0;
      for (int i = 1; i < WZ_D; i++) wzd[i] <= wzd[i-1];
    end
  end

  always_comb begin
    if (wzd[WZ_D-1]) begin
      result.out_x     = '0;
      result.out_y     = '0;
      result.out_z     = '0;
      result.w_is_zero = 1'b1;
      result.clipped   = 1'b0;
    end else begin
      result.out_x     = quos[0];
      result.out_y     = quos[1];
      result.out_z     = quos[2];
      result.w_is_zero = 1'b0;
      result.clipped   = clips[0] | clips[1] | clips[2];
    end
  end

`ifndef SYNTH
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.w_is_zero && result.clipped))
    else $error("w_is_zero and clipped both set");

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.w_is_zero |->
      result.out_x == '0 && result.out_y == '0 && result.out_z == '0)
    else $error("nonzero output with zero w");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");
`endif

endmodule

@@ rtl/vtpd_dot.sv @@
// Two-stage row dot product with implied w of one: multiply, then sum.
module vtpd_dot
  import vtpd_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  row_t                    row,
  input  point_t                  pt,
  output logic signed [SUM_W-1:0] sum
);

  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] py;
  logic signed [PROD_W-1:0] pz;
  logic signed [PROD_W-1:0] pt3;

  always_ff @(posedge clk) begin
    if (en) begin
      px  <= row.c0 * pt.point_x;
      py  <= row.c1 * pt.point_y;
      pz  <= row.c2 * pt.point_z;
      pt3 <= PROD_W'(row.c3) <<< FRACTION_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= SUM_W'(px) + SUM_W'(py) + SUM_W'(pz) + SUM_W'(pt3);
    end
  end

endmodule

@@ rtl/vtpd_div.sv @@
// Pipelined signed restoring divider, one quotient bit per stage, with saturation.
module vtpd_div
  import vtpd_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [SUM_W-1:0] num,
  input  logic signed [SUM_W-1:0] den,
  output logic signed [QUO_W-1:0] quo,
  output logic                    clip
);

  localparam int MW = SUM_W - 1;
  localparam int NW = MW + FRACTION_BITS;
  localparam int CW = MW + QUO_W;

  logic [NW-1:0]    rem [QUO_W+1];
  logic [MW-1:0]    dv  [QUO_W+1];
  logic [QUO_W-1:0] q   [QUO_W+1];
  logic             ng  [QUO_W+1];
  logic             ov  [QUO_W+1];

  logic [SUM_W-1:0] num_abs;
  logic [SUM_W-1:0] den_abs;
  logic [NW-1:0]    n_sh;

  assign num_abs = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
  assign den_abs = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
  assign n_sh    = {num_abs[MW-1:0], {FRACTION_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= n_sh;
      dv[0]  <= den_abs[MW-1:0];
      q[0]   <= '0;
      ng[0]  <= num[SUM_W-1] ^ den[SUM_W-1];
      ov[0]  <= CW'(n_sh) >= {den_abs[MW-1:0], {QUO_W{1'b0}}};
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int SH = QUO_W - 1 - k;
    logic [CW-1:0] dsh;
    logic [CW-1:0] rw;
    logic          take;
    assign dsh  = CW'(dv[k]) << SH;
    assign rw   = CW'(rem[k]);
    assign take = rw >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? NW'(rw - dsh) : rem[k];
        dv[k+1]  <= dv[k];
        q[k+1]   <= q[k] | (take ? (QUO_W'(1) << SH) : '0);
        ng[k+1]  <= ng[k];
        ov[k+1]  <= ov[k];
      end
    end
  end

  logic [QUO_W:0] lim;
  logic           sat;
  logic [QUO_W:0] mag;

  assign lim = ng[QUO_W] ? (QUO_W+1)'(1) << (QUO_W-1)
                         : ((QUO_W+1)'(1) << (QUO_W-1)) - (QUO_W+1)'(1);
  assign sat = ov[QUO_W] || ({1'b0, q[QUO_W]} > lim);
  assign mag = sat ? lim : {1'b0, q[QUO_W]};

  always_ff @(posedge clk) begin
    if (en) begin
      quo  <= ng[QUO_W] ? QUO_W'(-mag) : mag[QUO_W-1:0];
      clip <= sat;
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench for the vertex transform with perspective divide: directed cases plus random matrices and points.
module tb;
  import vtpd_pkg::*;

  localparam int FRACTION_BITS = 16;
  localparam int LATENCY = 36;
  localparam int WATCHDOG_LIMIT = 20000;

  class vertex_scoreboard;
    logic [63:0] matrix_regs [NUM_REGS];
    result_t     pending [$];
    int          errors;
    int          checked;
    int          clip_count;
    int          zero_w_count;

    function new();
      errors = 0;
      checked = 0;
      clip_count = 0;
      zero_w_count = 0;
      matrix_regs[0] = 64'd1 << FRACTION_BITS;
      matrix_regs[1] = 64'd0;
      matrix_regs[2] = (64'd1 << FRACTION_BITS) << 32;
      matrix_regs[3] = 64'd0;
      matrix_regs[4] = 64'd0;
      matrix_regs[5] = 64'd1 << FRACTION_BITS;
      matrix_regs[6] = 64'd0;
      matrix_regs[7] = (64'd1 << FRACTION_BITS) << 32;
    endfunction

    function logic signed [31:0] coef(int row, int col);
      logic [63:0] r;
      r = matrix_regs[row * 2 + col / 2];
      return (col % 2) ? r[63:32] : r[31:0];
    endfunction

    function logic signed [127:0] row_sum(int row, point_t p);
      logic signed [127:0] acc;
      acc = 128'(coef(row, 3)) <<< FRACTION_BITS;
      acc += 128'(coef(row, 0)) * 128'(p.point_x);
      acc += 128'(coef(row, 1)) * 128'(p.point_y);
      acc += 128'(coef(row, 2)) * 128'(p.point_z);
      return acc;
    endfunction

    function logic [31:0] quotient(logic signed [127:0] num, logic signed [127:0] w,
                                   ref logic clip);
      logic        neg;
      logic [127:0] n;
      logic [127:0] d;
      logic [127:0] q;
      logic [127:0] limit;
      neg = num[127] != w[127];
      n = num[127] ? -num : num;
      d = w[127] ? -w : w;
      n = n << FRACTION_BITS;
      q = n / d;
      limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > limit) begin
        q = limit;
        clip = 1'b1;
      end
      return neg ? 32'(-q) : q[31:0];
    endfunction

    function void note_point(point_t p);
      result_t r;
      logic signed [127:0] w;
      logic clip;
      clip = 1'b0;
      r = '0;
      w = row_sum(3, p);
      if (w == 0) begin
        r.w_is_zero = 1'b1;
      end else begin
        r.out_x = quotient(row_sum(0, p), w, clip);
        r.out_y = quotient(row_sum(1, p), w, clip);
        r.out_z = quotient(row_sum(2, p), w, clip);
        r.clipped = clip;
      end
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.clipped) clip_count++;
      if (want.w_is_zero) zero_w_count++;
      if (got.out_x !== want.out_x) begin
        $error("out_x expected %h actual %h", want.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== want.out_y) begin
        $error("out_y expected %h actual %h", want.out_y, got.out_y);
        errors++;
      end
      if (got.out_z !== want.out_z) begin
        $error("out_z expected %h actual %h", want.out_z, got.out_z);
        errors++;
      end
      if (got.w_is_zero !== want.w_is_zero) begin
        $error("w_is_zero expected %b actual %b", want.w_is_zero, got.w_is_zero);
        errors++;
      end
      if (got.clipped !== want.clipped) begin
        $error("clipped expected %b actual %b", want.clipped, got.clipped);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  point_t      point;
  logic        point_valid;
  logic        point_ready;
  result_t     result;
  logic        result_valid;
  logic        result_ready;

  vertex_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_cycles;
  int idle_cycles;
  int points_sent;
  int configs_used;

  vertex_transform_perspective_divide #(.FRACTION_BITS(FRACTION_BITS)) u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .point(point), .point_valid(point_valid), .point_ready(point_ready),
    .result(result), .result_valid(result_valid), .result_ready(result_ready)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (point_valid && point_ready) begin
        sb.note_point(point);
        points_sent++;
      end
      if (result_valid && result_ready) sb.check_result(result);
      if ((point_valid && point_ready) || (result_valid && result_ready) || psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("vertex_transform_perspective_divide: mismatch");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(int index, logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(index * 8);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.matrix_regs[index] = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_point(point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      point_valid <= 1'b0;
      @(negedge clk);
    end
    point <= p;
    point_valid <= 1'b1;
    do @(posedge clk); while (!point_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    point_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: return 32'($signed($urandom_range(64)) - 32);
      default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.point_x = rand_coord();
    p.point_y = rand_coord();
    p.point_z = rand_coord();
    return p;
  endfunction

  task automatic load_matrix(int kind);
    for (int i = 0; i < NUM_REGS; i++) begin
      logic [31:0] lo;
      logic [31:0] hi;
      case (kind)
        0: begin
          lo = 32'h8000_0000;
          hi = 32'h7FFF_FFFF;
        end
        1: begin
          lo = 32'hFFFF_FFFF;
          hi = 32'h0000_0001;
        end
        default: begin
          lo = rand_coord();
          hi = rand_coord();
        end
      endcase
      write_reg(i, {hi, lo});
    end
    configs_used++;
  endtask

  initial begin
    point_t p;
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    point = '0;
    point_valid = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 0;
    idle_cycles = 0;
    points_sent = 0;
    configs_used = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity matrix: extremes and zero point
    send_point('0);
    send_point({32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000});
    send_point({32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
    send_point({32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000});
    drain();

    // zero projective row gives zero w
    write_reg(6, 64'd0);
    write_reg(7, 64'd0);
    send_point({32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF});
    send_point('0);
    drain();

    // small w forces saturation both ways
    write_reg(7, {32'd1, 32'd0});
    write_reg(1, {32'h7FFF_FFFF, 32'd0});
    write_reg(3, {32'h8000_0000, 32'd0});
    send_point('0);
    send_point({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    drain();

    load_matrix(0);
    send_point({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_point({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_point({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    drain();
    load_matrix(1);
    send_point({32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001});
    send_point({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 27 : 0;
      for (int blk = 0; blk < 5; blk++) begin
        load_matrix(2);
        // keep w away from zero most of the time
        if ($urandom_range(3) != 0) begin
          write_reg(6, {32'($urandom_range(255)), 32'($urandom_range(255))});
          write_reg(7, {32'(($urandom_range(4) + 1) << 16), 32'($urandom_range(255))});
        end
        if (phase == 2 && blk == 0) hold_off_cycles = 200;
        for (int k = 0; k < 100; k++) send_point(rand_point());
        drain();
      end
    end

    $display("sent %0d points over %0d matrices; checked %0d results",
             points_sent, configs_used, sb.checked);
    $display("saturated results %0d, zero-w results %0d", sb.clip_count, sb.zero_w_count);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("vertex_transform_perspective_divide: match");
    end else begin
      $display("vertex_transform_perspective_divide: mismatch");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/vtpd_pkg.sv
rtl/vtpd_dot.sv
rtl/vtpd_div.sv
rtl/vertex_transform_perspective_divide.sv
tb/tb.sv
